@@ rtl/core/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the credit counter checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held low.
`define CCBR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that is also checked while reset is held low.
`define CCBR_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

@@ rtl/core/ccbr_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Credit counter package
// Opcodes, register indexes, widths and reset values shared by the core.
// ---------------------------------------------------------------------------
package ccbr_pkg;

    localparam int CREDIT_WIDTH_DEF = 16;
    localparam int STAT_WIDTH_DEF   = 32;
    localparam int OP_WIDTH         = 3;
    localparam int CFG_INDEX_WIDTH  = 3;

    // Register reset values, truncated to the credit width where used.
    localparam int RST_INITIAL_CREDITS = 64;
    localparam int RST_MAX_CREDITS     = 64;
    localparam int RST_MIN_CREDITS     = 8;
    localparam int RST_PARTIAL_RESERVE = 0;
    localparam int RST_BATCH_THRESHOLD = 1;

    typedef enum logic [OP_WIDTH-1:0] {
        OP_ACQUIRE     = 3'd0,
        OP_PARTIAL     = 3'd1,
        OP_RETURN      = 3'd2,
        OP_BATCH       = 3'd3,
        OP_RESET_STATS = 3'd4,
        OP_RESTART     = 3'd5,
        OP_QUERY       = 3'd6
    } ccbr_op_t;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_INITIAL_CREDITS = 3'd0,
        CFG_MAX_CREDITS     = 3'd1,
        CFG_MIN_CREDITS     = 3'd2,
        CFG_RESERVE_ENABLE  = 3'd3,
        CFG_PARTIAL_RESERVE = 3'd4,
        CFG_BATCH_THRESHOLD = 3'd5
    } ccbr_cfg_t;

    // Control handed from the handshake stage to the credit engine.
    typedef struct packed {
        logic     fire;
        ccbr_op_t op;
    } ccbr_ctrl_t;

endpackage

@@ rtl/core/ccbr_engine.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Credit engine
// Configuration registers, credit state and statistics, and the
// update that one operation applies to them.
// ---------------------------------------------------------------------------
module ccbr_engine
    import ccbr_pkg::*;
#(
    parameter int CREDIT_WIDTH = CREDIT_WIDTH_DEF,
    parameter int STAT_WIDTH   = STAT_WIDTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_addr,
    input  logic [CREDIT_WIDTH-1:0]    cfg_wdata,
    input  ccbr_ctrl_t                 ctrl,
    input  logic [CREDIT_WIDTH-1:0]    amount,
    output logic                       res_blocked,
    output logic [CREDIT_WIDTH-1:0]    res_granted,
    output logic [CREDIT_WIDTH-1:0]    res_available,
    output logic                       res_backpressured,
    output logic [CREDIT_WIDTH-1:0]    res_lowest,
    output logic [CREDIT_WIDTH-1:0]    res_highest,
    output logic [STAT_WIDTH-1:0]      res_attempts,
    output logic [STAT_WIDTH-1:0]      res_successes,
    output logic [STAT_WIDTH-1:0]      res_refusals,
    output logic [STAT_WIDTH-1:0]      res_partials,
    output logic [STAT_WIDTH-1:0]      res_returned,
    output logic [STAT_WIDTH-1:0]      res_flushes
);

    localparam int CW = CREDIT_WIDTH;
    localparam int SW = STAT_WIDTH;

    logic [CW-1:0] initial_reg, max_reg, min_reg, reserve_reg, threshold_reg;
    logic          reserve_en_reg;

    logic [CW-1:0] credits_reg, credits_next;
    logic [CW-1:0] pending_reg, pending_next;
    logic [CW-1:0] low_reg, low_next;
    logic [CW-1:0] high_reg, high_next;
    logic [SW-1:0] attempts_reg, attempts_next;
    logic [SW-1:0] successes_reg, successes_next;
    logic [SW-1:0] refusals_reg, refusals_next;
    logic [SW-1:0] partials_reg, partials_next;
    logic [SW-1:0] returned_reg, returned_next;
    logic [SW-1:0] flushes_reg, flushes_next;

    logic [CW-1:0] floor_lvl;
    logic [CW:0]   acq_need;
    logic          acq_ok;
    logic [CW-1:0] usable;
    logic [CW-1:0] part_grant;
    logic [CW:0]   pend_sum;
    logic [CW-1:0] pend_sat;
    logic          flush_hit;
    logic [CW-1:0] ret_amt;
    logic [CW:0]   ret_sum;
    logic [CW-1:0] ret_credits;
    logic          do_return;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            initial_reg    <= CW'(RST_INITIAL_CREDITS);
            max_reg        <= CW'(RST_MAX_CREDITS);
            min_reg        <= CW'(RST_MIN_CREDITS);
            reserve_en_reg <= 1'b0;
            reserve_reg    <= CW'(RST_PARTIAL_RESERVE);
            threshold_reg  <= CW'(RST_BATCH_THRESHOLD);
        end else if (cfg_we) begin
            unique case (ccbr_cfg_t'(cfg_addr))
                CFG_INITIAL_CREDITS: initial_reg    <= cfg_wdata;
                CFG_MAX_CREDITS:     max_reg        <= cfg_wdata;
                CFG_MIN_CREDITS:     min_reg        <= cfg_wdata;
                CFG_RESERVE_ENABLE:  reserve_en_reg <= cfg_wdata[0];
                CFG_PARTIAL_RESERVE: reserve_reg    <= cfg_wdata;
                CFG_BATCH_THRESHOLD: threshold_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Shared arithmetic, all one bit wider where a sum must not wrap.
    always_comb begin
        floor_lvl  = (reserve_en_reg && (reserve_reg > min_reg)) ? reserve_reg : min_reg;
        acq_need   = {1'b0, amount} + {1'b0, floor_lvl};
        acq_ok     = ({1'b0, credits_reg} >= acq_need);
        usable     = (credits_reg > floor_lvl) ? (credits_reg - floor_lvl) : '0;
        part_grant = (amount < usable) ? amount : usable;
        pend_sum   = {1'b0, pending_reg} + {1'b0, amount};
        pend_sat   = pend_sum[CW] ? '1 : pend_sum[CW-1:0];
        flush_hit  = (pend_sat >= threshold_reg);
        ret_amt    = (ccbr_op_t'(ctrl.op) == OP_RETURN) ? amount : pend_sat;
        ret_sum    = {1'b0, credits_reg} + {1'b0, ret_amt};
        ret_credits = (ret_sum < {1'b0, max_reg}) ? ret_sum[CW-1:0] : max_reg;
    end

    always_comb begin
        credits_next   = credits_reg;
        pending_next   = pending_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        attempts_next  = attempts_reg;
        successes_next = successes_reg;
        refusals_next  = refusals_reg;
        partials_next  = partials_reg;
        returned_next  = returned_reg;
        flushes_next   = flushes_reg;
        res_blocked    = 1'b0;
        res_granted    = '0;
        do_return      = 1'b0;

        unique case (ctrl.op)
            OP_ACQUIRE: begin
                attempts_next = attempts_reg + SW'(1);
                if (!acq_ok) begin
                    res_blocked   = 1'b1;
                    refusals_next = refusals_reg + SW'(1);
                end else begin
                    credits_next   = credits_reg - amount;
                    res_granted    = amount;
                    successes_next = successes_reg + SW'(1);
                    if (credits_next < low_reg) begin
                        low_next = credits_next;
                    end
                end
            end
            OP_PARTIAL: begin
                attempts_next = attempts_reg + SW'(1);
                if (usable == '0) begin
                    refusals_next = refusals_reg + SW'(1);
                end else begin
                    res_granted   = part_grant;
                    credits_next  = credits_reg - part_grant;
                    partials_next = partials_reg + SW'(1);
                    if (credits_next < low_reg) begin
                        low_next = credits_next;
                    end
                end
                // A zero request with usable credits still counts as a partial.
                res_blocked = (res_granted == '0);
            end
            OP_RETURN: begin
                do_return = 1'b1;
            end
            OP_BATCH: begin
                if (flush_hit) begin
                    pending_next = '0;
                    if (pend_sat != '0) begin
                        do_return    = 1'b1;
                        flushes_next = flushes_reg + SW'(1);
                    end
                end else begin
                    pending_next = pend_sat;
                end
            end
            OP_RESET_STATS: begin
                attempts_next  = '0;
                successes_next = '0;
                refusals_next  = '0;
                partials_next  = '0;
                returned_next  = '0;
                flushes_next   = '0;
                low_next       = initial_reg;
                high_next      = initial_reg;
            end
            OP_RESTART: begin
                credits_next = initial_reg;
            end
            default: ;
        endcase

        if (do_return) begin
            credits_next  = ret_credits;
            returned_next = returned_reg + SW'(ret_amt);
            if (ret_credits > high_reg) begin
                high_next = ret_credits;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            credits_reg   <= CW'(RST_INITIAL_CREDITS);
            pending_reg   <= '0;
            low_reg       <= CW'(RST_INITIAL_CREDITS);
            high_reg      <= CW'(RST_INITIAL_CREDITS);
            attempts_reg  <= '0;
            successes_reg <= '0;
            refusals_reg  <= '0;
            partials_reg  <= '0;
            returned_reg  <= '0;
            flushes_reg   <= '0;
        end else if (ctrl.fire) begin
            credits_reg   <= credits_next;
            pending_reg   <= pending_next;
            low_reg       <= low_next;
            high_reg      <= high_next;
            attempts_reg  <= attempts_next;
            successes_reg <= successes_next;
            refusals_reg  <= refusals_next;
            partials_reg  <= partials_next;
            returned_reg  <= returned_next;
            flushes_reg   <= flushes_next;
        end
    end

    assign res_available     = credits_next;
    assign res_backpressured = (credits_next <= floor_lvl);
    assign res_lowest        = low_next;
    assign res_highest       = high_next;
    assign res_attempts      = attempts_next;
    assign res_successes     = successes_next;
    assign res_refusals      = refusals_next;
    assign res_partials      = partials_next;
    assign res_returned      = returned_next;
    assign res_flushes       = flushes_next;

endmodule

@@ rtl/core/credit_counter_with_batch_return_core.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Credit counter with batch return
// Credit pool with floor, saturating returns, batched returns and statistics.
// ---------------------------------------------------------------------------
// The core takes one operation beat per cycle while the output is not
// stalled, and returns exactly one result beat for it: the beat is
// captured in an input register, the credit engine applies it in
// combinational logic, and the result lands in an output register. The
// loop that sets the rate is the credit state update, one compare and one
// add or subtract wide, which completes each cycle. s_tready stays high
// while the input register is empty or the output register is free or
// being drained, so a stalled result still lets one beat into the
// input register. Configuration writes are taken at any time and must
// only be made while no beat is in flight.
module credit_counter_with_batch_return_core
    import ccbr_pkg::*;
#(
    parameter int CREDIT_WIDTH = CREDIT_WIDTH_DEF,
    parameter int STAT_WIDTH   = STAT_WIDTH_DEF,
    localparam int IN_BITS     = OP_WIDTH + CREDIT_WIDTH,
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS    = 2 + 4 * CREDIT_WIDTH + 6 * STAT_WIDTH,
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_addr,
    input  logic [CREDIT_WIDTH-1:0]    cfg_wdata,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // opcode, amount
    input  logic [IN_TDATA_W-1:0]      s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // blocked, granted, available, backpressured, lowest_seen, highest_seen,
    // attempt_count, success_count, block_count, partial_count,
    // returned_total, flush_count
    output logic [OUT_TDATA_W-1:0]     m_tdata
);

    localparam int CW = CREDIT_WIDTH;
    localparam int SW = STAT_WIDTH;

    logic                in_valid_reg, in_valid_next;
    logic [OP_WIDTH-1:0] in_op_reg;
    logic [CW-1:0]       in_amount_reg;
    logic                out_valid_reg, out_valid_next;
    logic [OUT_BITS-1:0] out_data_reg;

    logic       advance;
    logic       in_take;
    ccbr_ctrl_t ctrl;

    logic          res_blocked, res_backpressured;
    logic [CW-1:0] res_granted, res_available, res_lowest, res_highest;
    logic [SW-1:0] res_attempts, res_successes, res_refusals;
    logic [SW-1:0] res_partials, res_returned, res_flushes;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    assign ctrl.fire = advance;
    assign ctrl.op   = ccbr_op_t'(in_op_reg);

    always_comb begin
        in_valid_next = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_op_reg     <= s_tdata[OP_WIDTH-1:0];
            in_amount_reg <= s_tdata[IN_BITS-1:OP_WIDTH];
        end
        if (advance) begin
            out_data_reg <= {res_flushes, res_returned, res_partials, res_refusals,
                             res_successes, res_attempts, res_highest, res_lowest,
                             res_backpressured, res_available, res_granted,
                             res_blocked};
        end
    end

    ccbr_engine #(
        .CREDIT_WIDTH(CREDIT_WIDTH),
        .STAT_WIDTH  (STAT_WIDTH)
    ) u_engine (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .ctrl             (ctrl),
        .amount           (in_amount_reg),
        .res_blocked      (res_blocked),
        .res_granted      (res_granted),
        .res_available    (res_available),
        .res_backpressured(res_backpressured),
        .res_lowest       (res_lowest),
        .res_highest      (res_highest),
        .res_attempts     (res_attempts),
        .res_successes    (res_successes),
        .res_refusals     (res_refusals),
        .res_partials     (res_partials),
        .res_returned     (res_returned),
        .res_flushes      (res_flushes)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(out_data_reg);

endmodule

@@ rtl/core/ccbr_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Credit counter checker
// Port-level assertions on the result stream, bound to the core.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ccbr_checker
    import ccbr_pkg::*;
#(
    parameter int CREDIT_WIDTH = CREDIT_WIDTH_DEF,
    parameter int STAT_WIDTH   = STAT_WIDTH_DEF,
    localparam int OUT_BITS    = 2 + 4 * CREDIT_WIDTH + 6 * STAT_WIDTH,
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int CW      = CREDIT_WIDTH;
    localparam int GR_LO   = 1;
    localparam int LOW_LO  = 2 + 2 * CW;
    localparam int HIGH_LO = 2 + 3 * CW;

    logic          res_blocked;
    logic [CW-1:0] res_granted, res_lowest, res_highest;

    assign res_blocked = m_tdata[0];
    assign res_granted = m_tdata[GR_LO +: CW];
    assign res_lowest  = m_tdata[LOW_LO +: CW];
    assign res_highest = m_tdata[HIGH_LO +: CW];

    // A refused or empty acquisition never hands out credits.
    `CCBR_ASSERT(a_blocked_no_grant, aclk, aresetn, m_tvalid && res_blocked |-> res_granted == '0, "blocked result carries a nonzero grant")

    // The low mark only falls and the high mark only rises from a common start.
    `CCBR_ASSERT(a_marks_ordered, aclk, aresetn, m_tvalid |-> res_lowest <= res_highest, "lowest_seen above highest_seen")

    // A draining output always leaves room for the next beat.
    `CCBR_ASSERT(a_ready_follows, aclk, aresetn, m_tready |-> s_tready, "input stalled while output drains")

    `CCBR_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result beat changed")

    `CCBR_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result beat presented after reset")

endmodule

bind credit_counter_with_batch_return_core ccbr_checker #(
    .CREDIT_WIDTH(CREDIT_WIDTH),
    .STAT_WIDTH  (STAT_WIDTH)
) u_ccbr_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);
